[design/clns_pkg.sv]
package clns_pkg;

  localparam logic [1:0] ACT_INIT = 2'd0;
  localparam logic [1:0] ACT_CMD  = 2'd1;
  localparam logic [1:0] ACT_CHAR = 2'd2;

  localparam int HOLD_W = 17;
  localparam int POS_W  = 5;

  localparam logic [HOLD_W-1:0] HOLD_SETUP   = 17'd100;
  localparam logic [HOLD_W-1:0] HOLD_STROBE  = 17'd1;
  localparam logic [HOLD_W-1:0] HOLD_POWERUP = 17'd50000;
  localparam logic [HOLD_W-1:0] HOLD_SETTLE  = 17'd10000;

  localparam logic [POS_W-1:0] POS_MAX   = 5'd16;
  localparam logic [3:0]       WRAP_RST  = 4'd8;
  localparam logic [3:0]       INIT_LAST = 4'd11;
  localparam logic [3:0]       BYTE_LAST = 4'd3;
  localparam logic [3:0]       BYTE_FIRST = 4'd2;
  localparam logic [7:0]       LINE2_CMD = 8'hC0;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] value;
    logic       start_req;
  } in_t;

  typedef struct packed {
    logic              register_select;
    logic [3:0]        nibble;
    logic              enable;
    logic [HOLD_W-1:0] hold_us;
    logic              last;
  } out_t;

  typedef struct packed {
    logic load;
    logic emit_power;
    logic emit_nib;
  } cmd_t;

  typedef struct packed {
    logic slot_free;
    logic run_end;
  } status_t;

  function automatic logic [3:0] init_nibble(input logic [3:0] idx);
    logic [3:0] n;
    unique case (idx)
      4'd0, 4'd1, 4'd2: n = 4'b0011;
      4'd3, 4'd4:       n = 4'b0010;
      4'd5:             n = 4'b1000;
      4'd7:             n = 4'b1100;
      4'd9:             n = 4'b0001;
      4'd11:            n = 4'b0110;
      default:          n = 4'b0000;
    endcase
    return n;
  endfunction

  function automatic logic [HOLD_W-1:0] init_extra(input logic [3:0] idx);
    logic [HOLD_W-1:0] e;
    unique case (idx)
      4'd0, 4'd1: e = 17'd4500;
      4'd2:       e = 17'd150;
      4'd9:       e = 17'd2000;
      4'd11:      e = 17'd100000;
      default:    e = '0;
    endcase
    return e;
  endfunction

endpackage

[design/clns_ctrl.sv]
module clns_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [1:0]        in_action,
  input  clns_pkg::status_t status,
  output logic              busy,
  output clns_pkg::cmd_t    cmd
);

  typedef enum logic [1:0] {S_IDLE, S_POWER, S_NIB} state_t;

  state_t state_r, state_nxt;

  assign busy = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          unique case (in_action) inside
            clns_pkg::ACT_INIT: begin
              cmd.load = 1'b1;
              state_nxt = S_POWER;
            end
            clns_pkg::ACT_CMD, clns_pkg::ACT_CHAR: begin
              cmd.load = 1'b1;
              state_nxt = S_NIB;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_POWER: begin
        if (status.slot_free) begin
          cmd.emit_power = 1'b1;
          state_nxt = S_NIB;
        end
      end
      S_NIB: begin
        if (status.slot_free) begin
          cmd.emit_nib = 1'b1;
          if (status.run_end) state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[design/clns_dp.sv]
module clns_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  clns_pkg::in_t     in_data,
  input  clns_pkg::cmd_t    cmd,
  input  logic              cfg_we,
  input  logic [3:0]        cfg_data,
  input  logic              out_stall,
  output logic              out_valid,
  output clns_pkg::out_t    out_data,
  output clns_pkg::status_t status
);

  logic [3:0]               wrap_r;
  logic [clns_pkg::POS_W-1:0] pos_r, pos_nxt, pos_eff;
  logic                     init_r;
  logic                     rs_r;
  logic [7:0]               byte_r;
  logic [3:0]               idx_r;
  logic [1:0]               phase_r;
  logic                     out_valid_r;
  clns_pkg::out_t           out_r;

  logic                     wrap_hit;
  logic                     last_nib;
  logic [3:0]               nib;
  logic                     rs;
  logic [clns_pkg::HOLD_W-1:0] extra, hold;
  clns_pkg::out_t           phase_out;

  assign pos_eff  = in_data.start_req ? '0 : pos_r;
  assign wrap_hit = (pos_eff == {1'b0, wrap_r});

  always_comb begin
    pos_nxt = pos_r;
    if (cmd.load && in_data.action == clns_pkg::ACT_CHAR) begin
      pos_nxt = (pos_eff < clns_pkg::POS_MAX) ? pos_eff + 1'b1 : pos_eff;
    end
  end

  assign last_nib = init_r ? (idx_r == clns_pkg::INIT_LAST) : (idx_r == clns_pkg::BYTE_LAST);

  always_comb begin
    if (init_r) begin
      nib   = clns_pkg::init_nibble(idx_r);
      rs    = 1'b0;
      extra = clns_pkg::init_extra(idx_r);
    end else begin
      if (idx_r < clns_pkg::BYTE_FIRST) begin
        nib = idx_r[0] ? clns_pkg::LINE2_CMD[3:0] : clns_pkg::LINE2_CMD[7:4];
        rs  = 1'b0;
      end else begin
        nib = idx_r[0] ? byte_r[3:0] : byte_r[7:4];
        rs  = rs_r;
      end
      extra = idx_r[0] ? clns_pkg::HOLD_SETTLE : '0;
    end
    case (phase_r)
      2'd0:    hold = clns_pkg::HOLD_SETUP;
      2'd1:    hold = clns_pkg::HOLD_STROBE;
      2'd2:    hold = clns_pkg::HOLD_STROBE;
      default: hold = clns_pkg::HOLD_SETUP + extra;
    endcase
    phase_out.register_select = rs;
    phase_out.nibble          = nib;
    phase_out.enable          = (phase_r == 2'd2);
    phase_out.hold_us         = hold;
    phase_out.last            = (phase_r == 2'd3) && last_nib;
  end

  assign status.slot_free = !out_valid_r || !out_stall;
  assign status.run_end   = (phase_r == 2'd3) && last_nib;
  assign out_valid        = out_valid_r;
  assign out_data         = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wrap_r      <= clns_pkg::WRAP_RST;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) wrap_r <= cfg_data;
      pos_r <= pos_nxt;
      if (cmd.emit_power || cmd.emit_nib) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      init_r  <= (in_data.action == clns_pkg::ACT_INIT);
      rs_r    <= (in_data.action == clns_pkg::ACT_CHAR);
      byte_r  <= in_data.value;
      phase_r <= 2'd0;
      if (in_data.action == clns_pkg::ACT_CHAR && wrap_hit) begin
        idx_r <= '0;
      end else if (in_data.action == clns_pkg::ACT_INIT) begin
        idx_r <= '0;
      end else begin
        idx_r <= clns_pkg::BYTE_FIRST;
      end
    end else if (cmd.emit_nib) begin
      phase_r <= phase_r + 2'd1;
      if (phase_r == 2'd3) idx_r <= idx_r + 4'd1;
    end
    if (cmd.emit_power) begin
      out_r.register_select <= 1'b0;
      out_r.nibble          <= 4'b0000;
      out_r.enable          <= 1'b0;
      out_r.hold_us         <= clns_pkg::HOLD_POWERUP;
      out_r.last            <= 1'b0;
    end else if (cmd.emit_nib) begin
      out_r <= phase_out;
    end
  end

endmodule

[design/char_lcd_nibble_sequencer.sv]
// Channel   Direction  Handshake          Payload
// in_       input      in_valid/in_stall  clns_pkg::in_t  (action, value, start_req)
// out_      output     out_valid/out_stall clns_pkg::out_t (rs, nibble, enable, hold_us, last)
// cfg_      input      cfg_valid/cfg_ready cfg_data[3:0]   (wrap_position)
//
// One pin phase leaves per cycle through a registered output slot while out_stall is low.
// A request is loaded and then takes 8, 16 or 49 phases; the index and phase
// counters in the datapath set that figure. Action 3 is dropped at once.
// in_stall is high while a run is in progress; out_stall holds the slot.
// Synchronous reset sets wrap_position to 8 and the position count to 0.
module char_lcd_nibble_sequencer (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  clns_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output clns_pkg::out_t out_data,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [3:0]     cfg_data
);

  clns_pkg::cmd_t    cmd;
  clns_pkg::status_t status;
  logic              busy;

  assign in_stall  = busy;
  assign cfg_ready = 1'b1;

  clns_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_data.action),
    .status    (status),
    .busy      (busy),
    .cmd       (cmd)
  );

  clns_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .status    (status)
  );

endmodule

[design/clns_check.sv]
module clns_check (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_stall,
  input clns_pkg::in_t  in_data,
  input logic           out_valid,
  input logic           out_stall,
  input clns_pkg::out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled phase changed");

  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_data.action == clns_pkg::ACT_INIT ||
      in_data.action == clns_pkg::ACT_CMD || in_data.action == clns_pkg::ACT_CHAR)
    |=> in_stall)
    else $error("request accepted without starting a run");

  a_strobe_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.enable |-> out_data.hold_us == 17'd1 && !out_data.last)
    else $error("enable-high phase has wrong hold");

  a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_stall) && $past(rst_n) |-> out_valid && out_data.last)
    else $error("run ended without a marked last phase");

endmodule

bind char_lcd_nibble_sequencer clns_check u_clns_check (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

[bench/tb_top.sv]
`timescale 1ns / 1ps

class lcd_phase_scoreboard;
  clns_pkg::out_t phase_q[$];
  logic [3:0] wrap_pos;
  logic [clns_pkg::POS_W-1:0] char_pos;
  logic [3:0] init_nib[12];
  int unsigned init_wait[12];
  int errors;
  int phase_count;

  function new();
    wrap_pos = clns_pkg::WRAP_RST;
    char_pos = '0;
    errors = 0;
    phase_count = 0;
    init_nib = '{4'h3, 4'h3, 4'h3, 4'h2, 4'h2, 4'h8, 4'h0, 4'hC, 4'h0, 4'h1, 4'h0, 4'h6};
    init_wait = '{4500, 4500, 150, 0, 0, 0, 0, 0, 0, 2000, 0, 100000};
  endfunction

  function void set_wrap(logic [3:0] w);
    wrap_pos = w;
  endfunction

  function int pending();
    return phase_q.size();
  endfunction

  function void push_phase(logic rs, logic [3:0] nib, logic en, int unsigned hold);
    clns_pkg::out_t p;
    p.register_select = rs;
    p.nibble = nib;
    p.enable = en;
    p.hold_us = hold[clns_pkg::HOLD_W-1:0];
    p.last = 1'b0;
    phase_q.push_back(p);
  endfunction

  function void push_nibble(logic rs, logic [3:0] nib, int unsigned extra);
    push_phase(rs, nib, 1'b0, 100);
    push_phase(rs, nib, 1'b0, 1);
    push_phase(rs, nib, 1'b1, 1);
    push_phase(rs, nib, 1'b0, 100 + extra);
  endfunction

  function void push_byte(logic rs, logic [7:0] data_byte);
    push_nibble(rs, data_byte[7:4], 0);
    push_nibble(rs, data_byte[3:0], 10000);
  endfunction

  function void note_request(clns_pkg::in_t req);
    int first;
    clns_pkg::out_t p;
    first = phase_q.size();
    case (req.action)
      clns_pkg::ACT_INIT: begin
        push_phase(1'b0, 4'h0, 1'b0, 50000);
        for (int i = 0; i < 12; i++) push_nibble(1'b0, init_nib[i], init_wait[i]);
      end
      clns_pkg::ACT_CMD: begin
        push_byte(1'b0, req.value);
      end
      clns_pkg::ACT_CHAR: begin
        if (req.start_req) char_pos = '0;
        if (char_pos == {1'b0, wrap_pos}) push_byte(1'b0, clns_pkg::LINE2_CMD);
        push_byte(1'b1, req.value);
        if (char_pos < clns_pkg::POS_MAX) char_pos = char_pos + 1'b1;
      end
      default: begin
      end
    endcase
    if (phase_q.size() > first) begin
      p = phase_q.pop_back();
      p.last = 1'b1;
      phase_q.push_back(p);
    end
  endfunction

  function void check_phase(clns_pkg::out_t got);
    clns_pkg::out_t want;
    phase_count++;
    if (phase_q.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("phase %0d unexpected: rs=%0d nib=%h en=%0d hold=%0d last=%0d",
                 phase_count, got.register_select, got.nibble, got.enable,
                 got.hold_us, got.last);
      return;
    end
    want = phase_q.pop_front();
    if (got.register_select !== want.register_select || got.nibble !== want.nibble ||
        got.enable !== want.enable || got.hold_us !== want.hold_us ||
        got.last !== want.last) begin
      errors++;
      if (errors <= 10)
        $display({"phase %0d mismatch: exp rs=%0d nib=%h en=%0d hold=%0d last=%0d, ",
                  "got rs=%0d nib=%h en=%0d hold=%0d last=%0d"},
                 phase_count, want.register_select, want.nibble, want.enable,
                 want.hold_us, want.last, got.register_select, got.nibble,
                 got.enable, got.hold_us, got.last);
    end
  endfunction
endclass

module tb_top;

  localparam logic [1:0] ACT_NONE = 2'd3;
  localparam int SETTLE_CYCLES = 60;
  localparam int LIMIT_CYCLES = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  clns_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  clns_pkg::out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [3:0] cfg_data = 4'd0;

  int gap_max = 3;
  int stall_max = 3;
  int hold_off_cycles = 0;
  int cycles = 0;

  lcd_phase_scoreboard sb = new();

  char_lcd_nibble_sequencer dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) sb.note_request(in_data);
    if (rst_n && out_valid && !out_stall) sb.check_phase(out_data);
  end

  initial begin
    int n;
    forever begin
      n = (hold_off_cycles > 0) ? hold_off_cycles : $urandom_range(0, stall_max);
      hold_off_cycles = 0;
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(rst_n && out_valid));
    end
  end

  task automatic send_req(logic [1:0] act, logic [7:0] val, logic st);
    clns_pkg::in_t req;
    int gap;
    req.action = act;
    req.value = val;
    req.start_req = st;
    gap = $urandom_range(0, gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_wrap(logic [3:0] w);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= w;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_wrap(w);
  endtask

  task automatic random_burst(int count);
    int done;
    int pick;
    int len;
    done = 0;
    while (done < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        len = $urandom_range(1, 20);
        for (int i = 0; i < len; i++)
          send_req(clns_pkg::ACT_CHAR, 8'($urandom_range(0, 255)), i == 0);
        done += len;
      end else if (pick < 82) begin
        send_req(clns_pkg::ACT_CMD, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        done++;
      end else if (pick < 85) begin
        send_req(clns_pkg::ACT_INIT, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        done++;
      end else if (pick < 93) begin
        send_req(ACT_NONE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end else begin
        send_req(clns_pkg::ACT_CHAR, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        done++;
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_req(clns_pkg::ACT_INIT, 8'h00, 1'b0);
    send_req(clns_pkg::ACT_INIT, 8'hFF, 1'b1);
    send_req(clns_pkg::ACT_CMD, 8'h00, 1'b0);
    send_req(clns_pkg::ACT_CMD, 8'hFF, 1'b1);
    send_req(clns_pkg::ACT_CMD, 8'hA5, 1'b0);
    send_req(ACT_NONE, 8'hFF, 1'b1);
    send_req(ACT_NONE, 8'h00, 1'b0);
    send_req(clns_pkg::ACT_CHAR, 8'h00, 1'b1);
    for (int i = 1; i < 10; i++) send_req(clns_pkg::ACT_CHAR, 8'(i * 28), 1'b0);
    send_req(clns_pkg::ACT_CHAR, 8'hFF, 1'b0);
    send_req(clns_pkg::ACT_CHAR, 8'h5A, 1'b1);
    send_req(clns_pkg::ACT_CHAR, 8'h41, 1'b0);

    write_wrap(4'd1);
    random_burst(70);

    write_wrap(4'd15);
    gap_max = 0;
    stall_max = 0;
    random_burst(60);
    gap_max = 3;
    stall_max = 3;

    write_wrap(4'd0);
    random_burst(70);

    write_wrap(4'($urandom_range(2, 14)));
    hold_off_cycles = 300;
    random_burst(70);

    write_wrap(4'd8);
    random_burst(40);

    drain();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
